>>> rtl/lzp_pkg.sv
// Package: shared constants, codes and types of the LZP symbol decoder.
`timescale 1ns / 1ps
package lzp_pkg;

  // Default history depth in bytes
  localparam int unsigned MAX_BLOCK_BYTES_DEF = 1048576;
  // Context hash width and its byte shifts
  localparam int unsigned CTX_BITS = 20;
  localparam int unsigned SHIFT_B  = 6;
  localparam int unsigned SHIFT_C  = 12;
  // Epoch mark stored with each context entry
  localparam int unsigned EPOCH_BITS = 8;
  // Field widths
  localparam int unsigned SYM_BITS = 9;
  localparam int unsigned LEN_BITS = 21;
  localparam int unsigned CNT_BITS = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERRUN  = 2'd2,
    ST_COMPLETE = 2'd3
  } status_t;

  // Classified item passed from the front to the back through the queue
  typedef struct packed {
    logic                block_start;
    logic                is_copy;
    logic [7:0]          lit;
    logic [SYM_BITS-1:0] copy_len;   // 1 to 256
  } item_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } qpush_t;

endpackage

>>> rtl/lzp_front.sv
// Front end: takes symbols from the input stream and classifies them.
`timescale 1ns / 1ps
module lzp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  logic [lzp_pkg::SYM_BITS-1:0] symbol,
  input  logic                        block_start,
  output lzp_pkg::qpush_t             push,
  input  logic                        push_ready
);
  import lzp_pkg::*;

  logic  held;
  item_t item;

  assign s_ready   = !held || push_ready;
  assign push.valid = held;
  assign push.item  = item;

  // Hold one classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_ready) begin
      held <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item.block_start <= block_start;
      item.is_copy     <= symbol[SYM_BITS-1];
      item.lit         <= symbol[7:0];
      item.copy_len    <= {1'b0, symbol[7:0]} + SYM_BITS'(1);
    end
  end

endmodule

>>> rtl/lzp_queue.sv
// Two-entry queue between the front end and the execution back end.
`timescale 1ns / 1ps
module lzp_queue (
  input  logic            clk,
  input  logic            rst,
  input  lzp_pkg::qpush_t push,
  output logic            push_ready,
  output logic            pop_valid,
  output lzp_pkg::item_t  pop_item,
  input  logic            pop
);
  import lzp_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.item;
  end

endmodule

>>> rtl/lzp_back.sv
// Back end: context table, history memory and the byte sequencer.
`timescale 1ns / 1ps
module lzp_back #(
  parameter int unsigned MAX_BLOCK_BYTES = lzp_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lzp_pkg::LEN_BITS-1:0] expected_length,
  input  logic                        item_valid,
  input  lzp_pkg::item_t              item_in,
  output logic                        item_pop,
  output logic                        m_valid,
  input  logic                        m_ready,
  output logic [7:0]                  byte_a,
  output logic [7:0]                  byte_b,
  output logic [7:0]                  byte_c,
  output logic [7:0]                  byte_d,
  output logic [lzp_pkg::CNT_BITS-1:0] byte_count,
  output logic                        last_of_run,
  output lzp_pkg::status_t            status,
  output logic                        block_done
);
  import lzp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCK_BYTES);
  localparam int unsigned PW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned LW = (PW > LEN_BITS) ? PW : LEN_BITS;
  localparam int unsigned TW = EPOCH_BITS + AW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_EVAL, S_RD, S_WR, S_EMIT
  } state_t;

  state_t                state;
  logic                  resume;
  logic [CTX_BITS-1:0]   clr_cnt;
  logic [EPOCH_BITS-1:0] epoch;
  logic [PW-1:0]         pos;
  logic [23:0]           recent;
  item_t                 cur;
  logic [AW-1:0]         src;
  logic [SYM_BITS-1:0]   done;
  logic [7:0]            grp [4];
  logic [CNT_BITS-1:0]   n;
  logic                  grp_last;
  status_t               grp_st;

  logic [TW-1:0]         tbl [2**CTX_BITS];
  logic [TW-1:0]         tbl_rdata;
  logic [7:0]            hist [MAX_BLOCK_BYTES];
  logic [7:0]            hist_rdata;

  logic [CTX_BITS-1:0]   ctx;
  logic [LW-1:0]         lim;
  logic [LW-1:0]         pos_w;
  logic [LW-1:0]         left;
  logic                  out_free;
  logic                  tbl_we;
  logic [CTX_BITS-1:0]   tbl_waddr;
  logic [TW-1:0]         tbl_wdata;
  logic                  hist_we;
  logic [7:0]            hist_wdata;
  logic [AW-1:0]         hist_raddr;
  logic [EPOCH_BITS-1:0] epoch_inc;

  // Context hash of the last three bytes
  assign ctx = CTX_BITS'(recent[23:16]) ^ (CTX_BITS'(recent[15:8]) << SHIFT_B)
             ^ (CTX_BITS'(recent[7:0]) << SHIFT_C);

  // Length limit saturated to the history depth
  always_comb begin
    if (LW'(expected_length) > LW'(MAX_BLOCK_BYTES)) begin
      lim = LW'(MAX_BLOCK_BYTES);
    end else begin
      lim = LW'(expected_length);
    end
  end

  assign pos_w      = LW'(pos);
  assign left       = lim - pos_w;
  assign out_free   = !m_valid || m_ready;
  assign item_pop   = (state == S_IDLE) && item_valid;
  assign hist_raddr = src + AW'(done);
  assign epoch_inc  = epoch + EPOCH_BITS'(1);

  // Memory write controls
  always_comb begin
    tbl_we     = 1'b0;
    tbl_waddr  = ctx;
    tbl_wdata  = {epoch, pos[AW-1:0]};
    hist_we    = 1'b0;
    hist_wdata = cur.lit;
    case (state)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt;
        tbl_wdata = '0;
      end
      S_EVAL: begin
        if (pos_w < lim && !cur.is_copy) begin
          tbl_we  = 1'b1;
          hist_we = 1'b1;
        end
      end
      S_WR: begin
        hist_we    = 1'b1;
        hist_wdata = hist_rdata;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // Context table
  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_waddr] <= tbl_wdata;
    tbl_rdata <= tbl[ctx];
  end

  // History memory
  always_ff @(posedge clk) begin
    if (hist_we) hist[pos[AW-1:0]] <= hist_wdata;
    hist_rdata <= hist[hist_raddr];
  end

  // Sequencer with result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      resume   <= 1'b0;
      clr_cnt  <= '0;
      epoch    <= EPOCH_BITS'(1);
      pos      <= '0;
      recent   <= '0;
      m_valid  <= 1'b0;
      n        <= '0;
      grp_last <= 1'b0;
      grp_st   <= ST_OK;
      done     <= '0;
      src      <= '0;
      for (int i = 0; i < 4; i++) grp[i] <= '0;
    end else begin
      if (m_valid && m_ready) m_valid <= 1'b0;
      case (state)
        // Sweep the context table, then take or resume an item
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CTX_BITS'(1);
          if (clr_cnt == {CTX_BITS{1'b1}}) begin
            state <= resume ? S_LOOK : S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            cur <= item_in;
            if (item_in.block_start) begin
              pos    <= '0;
              recent <= '0;
              if (epoch_inc == '0) begin
                epoch  <= EPOCH_BITS'(1);
                resume <= 1'b1;
                state  <= S_CLEAR;
              end else begin
                epoch <= epoch_inc;
                state <= S_LOOK;
              end
            end else begin
              state <= S_LOOK;
            end
          end
        end
        // Table read at the current context is under way
        S_LOOK: begin
          state <= S_EVAL;
        end
        // Check the item and start its work
        S_EVAL: begin
          n        <= '0;
          grp_last <= 1'b1;
          grp_st   <= ST_OK;
          done     <= '0;
          for (int i = 0; i < 4; i++) grp[i] <= '0;
          state <= S_EMIT;
          if (pos_w >= lim) begin
            grp_st <= ST_COMPLETE;
          end else if (!cur.is_copy) begin
            grp[0] <= cur.lit;
            n      <= CNT_BITS'(1);
            pos    <= pos + PW'(1);
            recent <= {recent[15:0], cur.lit};
          end else if (LW'(cur.copy_len) > left) begin
            grp_st <= ST_OVERRUN;
          end else if (tbl_rdata[TW-1:AW] != epoch) begin
            grp_st <= ST_EMPTY;
          end else begin
            src   <= tbl_rdata[AW-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        // Append one copied byte to the group
        S_WR: begin
          grp[n[1:0]] <= hist_rdata;
          n           <= n + CNT_BITS'(1);
          done        <= done + SYM_BITS'(1);
          pos         <= pos + PW'(1);
          recent      <= {recent[15:0], hist_rdata};
          grp_last    <= (done + SYM_BITS'(1) == cur.copy_len);
          if (n == CNT_BITS'(3) || done + SYM_BITS'(1) == cur.copy_len) begin
            state <= S_EMIT;
          end else begin
            state <= S_RD;
          end
        end
        // Hand the group to the output register
        S_EMIT: begin
          if (out_free) begin
            m_valid     <= 1'b1;
            byte_a      <= grp[0];
            byte_b      <= grp[1];
            byte_c      <= grp[2];
            byte_d      <= grp[3];
            byte_count  <= n;
            last_of_run <= grp_last;
            status      <= grp_st;
            block_done  <= (pos_w >= lim);
            n           <= '0;
            for (int i = 0; i < 4; i++) grp[i] <= '0;
            state <= grp_last ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lzp_symbol_decoder_core.sv
// Top level of the LZP symbol decoder: stream ports, register, front, queue and back.
`timescale 1ns / 1ps
// Rebuilds a byte stream from entropy-decoded LZP symbols. A literal passes
// through the back end as queue pop, context table read, check and result;
// a copy is checked the same way, then each byte is read from the history
// memory and written back at the current position, and each result carries
// up to four bytes. After reset, and again after every 255th block start, a
// pass clears all 2^20 entries of the context table, during which no symbol
// is processed; symbols still queue up in the front end and the queue.
// expected_length is to be written only while idle; the block does not enforce this.
module lzp_symbol_decoder_core #(
  parameter int unsigned MAX_BLOCK_BYTES = lzp_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lzp_pkg::LEN_BITS-1:0] cfg_wr_data,    // expected_length
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [8:0] symbol, rest zero
  input  logic                         s_axis_tuser,   // [0] block_start
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] byte_a, [15:8] byte_b, [23:16] byte_c, [31:24] byte_d,
  // [34:32] byte_count, rest zero
  output logic [39:0]                  m_axis_tdata,
  output logic                         m_axis_tlast,   // last_of_run
  output logic [2:0]                   m_axis_tuser    // [1:0] status, [2] block_done
);
  import lzp_pkg::*;

  logic [LEN_BITS-1:0] expected_length;
  qpush_t              push;
  logic                push_ready;
  logic                q_valid;
  item_t               q_item;
  logic                q_pop;
  logic [7:0]          b_a, b_b, b_c, b_d;
  logic [CNT_BITS-1:0] b_cnt;
  status_t             st;
  logic                bdone;

  // Hold the length register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
    end else if (cfg_wr_en) begin
      expected_length <= cfg_wr_data;
    end
  end

  lzp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .symbol      (s_axis_tdata[SYM_BITS-1:0]),
    .block_start (s_axis_tuser),
    .push        (push),
    .push_ready  (push_ready)
  );

  lzp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  lzp_back #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .expected_length (expected_length),
    .item_valid      (q_valid),
    .item_in         (q_item),
    .item_pop        (q_pop),
    .m_valid         (m_axis_tvalid),
    .m_ready         (m_axis_tready),
    .byte_a          (b_a),
    .byte_b          (b_b),
    .byte_c          (b_c),
    .byte_d          (b_d),
    .byte_count      (b_cnt),
    .last_of_run     (m_axis_tlast),
    .status          (st),
    .block_done      (bdone)
  );

  // Pack the result item
  assign m_axis_tdata = {5'b0, b_cnt, b_d, b_c, b_b, b_a};
  assign m_axis_tuser = {bdone, st};

endmodule
